/* rtl/pvfd_pkg.sv */
package pvfd_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int INDEX_BITS_DEF  = 16;
  localparam int FRAC_BITS       = 8;
  localparam int QUEUE_DEPTH     = 2;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV_L,
    BK_DIV_R,
    BK_DONE
  } bk_state_t;

endpackage

/* rtl/pvfd_stream_if.sv */
interface pvfd_stream_if #(
  parameter int W = 1
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/peak_valley_feature_detector_core.sv */
// Peak/valley detector: front classifies one sample per cycle while the queue has room,
// back computes features. With the queue empty and back idle, the closing event passes
// through the queue, is loaded by the back, divided in BK_DIV_L then BK_DIV_R, and out_valid
// rises in BK_DONE. Throughput: one sample per cycle while the queue has room; a peak holds
// the back through both divides and BK_DONE; the 2-entry queue absorbs peaks meanwhile.
// Reset: synchronous active-low rst_n clears all detection state and the queue.
module peak_valley_feature_detector_core
  import pvfd_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int INDEX_BITS  = INDEX_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  logic                   in_is_last,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [INDEX_BITS-1:0]  out_peak_index,
  output logic [SAMPLE_BITS-1:0] out_peak_value,
  output logic [INDEX_BITS-1:0]  out_left_spread,
  output logic [INDEX_BITS-1:0]  out_right_spread,
  output logic [SAMPLE_BITS-1:0] out_height_max,
  output logic [SAMPLE_BITS:0]   out_height_mean_x2,
  output logic [SAMPLE_BITS+7:0] out_slope_max_q8,
  output logic [SAMPLE_BITS+7:0] out_slope_mean_q8
);

  localparam int EW = 3*SAMPLE_BITS + 3*INDEX_BITS;

  pvfd_stream_if #(.W(EW)) ev_q ();
  pvfd_stream_if #(.W(EW)) ev_b ();

  pvfd_front #(.SAMPLE_BITS(SAMPLE_BITS), .INDEX_BITS(INDEX_BITS)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_sample, .in_is_last,
    .ev_valid(ev_q.valid), .ev_ready(ev_q.ready), .ev_data(ev_q.data)
  );

  pvfd_queue #(.W(EW)) u_queue (
    .clk, .rst_n,
    .wr_valid(ev_q.valid), .wr_ready(ev_q.ready), .wr_data(ev_q.data),
    .rd_valid(ev_b.valid), .rd_ready(ev_b.ready), .rd_data(ev_b.data)
  );

  pvfd_back #(.SAMPLE_BITS(SAMPLE_BITS), .INDEX_BITS(INDEX_BITS)) u_back (
    .clk, .rst_n,
    .ev_valid(ev_b.valid), .ev_ready(ev_b.ready), .ev_data(ev_b.data),
    .out_valid, .out_ready, .out_peak_index, .out_peak_value, .out_left_spread,
    .out_right_spread, .out_height_max, .out_height_mean_x2, .out_slope_max_q8,
    .out_slope_mean_q8
  );

endmodule

/* rtl/pvfd_front.sv */
module pvfd_front
  import pvfd_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int INDEX_BITS  = INDEX_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  logic                   in_is_last,
  // event: peak value/pos, left valley value/pos, right valley value/pos
  output logic                   ev_valid,
  input  logic                   ev_ready,
  output logic [3*SAMPLE_BITS+3*INDEX_BITS-1:0] ev_data
);

  localparam int EW = 3*SAMPLE_BITS + 3*INDEX_BITS;
  localparam logic [INDEX_BITS-1:0] IMAX = {INDEX_BITS{1'b1}};

  logic signed [SAMPLE_BITS-1:0] prev_r, vval_r, pval_r;
  logic [INDEX_BITS-1:0] prev_pos_r, cnt_r, vpos_r, ppos_r;
  logic have_r, started_r, rising_r;

  logic signed [SAMPLE_BITS-1:0] s;
  logic fall, emit_mid, emit_end, emit;
  logic signed [SAMPLE_BITS-1:0] rv;
  logic [INDEX_BITS-1:0] rpos;
  logic signed [SAMPLE_BITS-1:0] pk_v;
  logic [INDEX_BITS-1:0] pk_pos;

  assign in_ready = ev_ready;
  assign s        = $signed(in_sample);
  assign fall     = have_r && (s < prev_r);
  assign emit_mid = have_r && !fall && started_r && !rising_r;
  // last sample still falling: a rising run turning now makes the peak the previous sample
  assign emit_end = in_is_last && fall && started_r;
  assign emit     = emit_mid || emit_end;
  assign pk_v     = (fall && rising_r) ? prev_r : pval_r;
  assign pk_pos   = (fall && rising_r) ? prev_pos_r : ppos_r;
  assign rv       = emit_mid ? prev_r : s;
  assign rpos     = emit_mid ? prev_pos_r : cnt_r;
  assign ev_valid = in_valid && emit;
  assign ev_data  = EW'({pk_v, pk_pos, vval_r, vpos_r, rv, rpos});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0; prev_pos_r <= '0; cnt_r <= '0; have_r <= 1'b0;
      started_r <= 1'b0; rising_r <= 1'b1; vval_r <= '0; vpos_r <= '0;
      pval_r <= '0; ppos_r <= '0;
    end else if (in_valid && in_ready) begin
      if (in_is_last) begin
        prev_r <= '0; prev_pos_r <= '0; cnt_r <= '0; have_r <= 1'b0;
        started_r <= 1'b0; rising_r <= 1'b1; vval_r <= '0; vpos_r <= '0;
        pval_r <= '0; ppos_r <= '0;
      end else begin
        if (have_r) begin
          if (fall) begin
            if (started_r && rising_r) begin
              pval_r <= prev_r; ppos_r <= prev_pos_r; rising_r <= 1'b0;
            end
          end else begin
            if (!started_r) begin
              vval_r <= prev_r; vpos_r <= prev_pos_r; started_r <= 1'b1;
            end else if (!rising_r) begin
              vval_r <= prev_r; vpos_r <= prev_pos_r;
            end
            rising_r <= 1'b1;
          end
        end
        prev_r     <= s;
        prev_pos_r <= cnt_r;
        have_r     <= 1'b1;
        if (cnt_r != IMAX) cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    ev_valid |-> in_valid) else $error("event without item");
  assert property (@(posedge clk) disable iff (!rst_n)
    !started_r |-> rising_r) else $error("falling before first valley");
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_is_last) |=> (cnt_r == '0 && !have_r))
    else $error("signal end not cleared");

endmodule

/* rtl/pvfd_queue.sv */
module pvfd_queue
  import pvfd_pkg::*;
#(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_valid,
  output logic         wr_ready,
  input  logic [W-1:0] wr_data,
  output logic         rd_valid,
  input  logic         rd_ready,
  output logic [W-1:0] rd_data
);

  logic [W-1:0] mem_r [QUEUE_DEPTH];
  logic [$clog2(QUEUE_DEPTH)-1:0] wp_r, rp_r;
  logic [$clog2(QUEUE_DEPTH):0] cnt_r;
  logic wr_en, rd_en;

  assign wr_ready = (cnt_r != QUEUE_DEPTH[$clog2(QUEUE_DEPTH):0]);
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_en) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + {{$clog2(QUEUE_DEPTH){1'b0}}, wr_en}
                     - {{$clog2(QUEUE_DEPTH){1'b0}}, rd_en};
    end
  end

endmodule

/* rtl/pvfd_back.sv */
module pvfd_back
  import pvfd_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int INDEX_BITS  = INDEX_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic ev_valid,
  output logic ev_ready,
  input  logic [3*SAMPLE_BITS+3*INDEX_BITS-1:0] ev_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [INDEX_BITS-1:0]      out_peak_index,
  output logic [SAMPLE_BITS-1:0]     out_peak_value,
  output logic [INDEX_BITS-1:0]      out_left_spread,
  output logic [INDEX_BITS-1:0]      out_right_spread,
  output logic [SAMPLE_BITS-1:0]     out_height_max,
  output logic [SAMPLE_BITS:0]       out_height_mean_x2,
  output logic [SAMPLE_BITS+7:0]     out_slope_max_q8,
  output logic [SAMPLE_BITS+7:0]     out_slope_mean_q8
);

  localparam int NW = SAMPLE_BITS + FRAC_BITS;   // dividend width
  localparam int CW = $clog2(NW + 1);

  bk_state_t st_r, st_nxt;
  logic signed [SAMPLE_BITS-1:0] pv, lv, rv;
  logic [INDEX_BITS-1:0] pp, lp, rp;
  logic [SAMPLE_BITS:0] dl_w, dr_w;
  logic [SAMPLE_BITS-1:0] dl_r, dr_r;
  logic [NW-1:0] quo_r, sl_r, sr_r;
  logic [INDEX_BITS:0] rem_r;
  logic [INDEX_BITS-1:0] div_r;
  logic [CW-1:0] step_r;
  logic [INDEX_BITS:0] trial;
  logic [INDEX_BITS:0] sub;
  logic [NW:0] ssum;
  logic [NW-1:0] smax;
  logic load, dstep, dlast;

  assign {pv, pp, lv, lp, rv, rp} = ev_data;
  assign dl_w = (pv >= lv) ? ({pv[SAMPLE_BITS-1], pv} - {lv[SAMPLE_BITS-1], lv})
                           : ({lv[SAMPLE_BITS-1], lv} - {pv[SAMPLE_BITS-1], pv});
  assign dr_w = (pv >= rv) ? ({pv[SAMPLE_BITS-1], pv} - {rv[SAMPLE_BITS-1], rv})
                           : ({rv[SAMPLE_BITS-1], rv} - {pv[SAMPLE_BITS-1], pv});

  assign ev_ready = (st_r == BK_IDLE);
  assign load     = ev_valid && ev_ready;
  assign dlast    = (step_r == CW'(NW - 1));

  // restoring divider, one quotient bit per cycle, dividend bits MSB first
  logic [NW-1:0] dvd_r;
  assign trial = {rem_r[INDEX_BITS-1:0], dvd_r[NW-1]};
  assign sub   = trial - {1'b0, div_r};
  assign dstep = (st_r == BK_DIV_L) || (st_r == BK_DIV_R);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      BK_IDLE:  if (load) st_nxt = BK_DIV_L;
      BK_DIV_L: if (dlast) st_nxt = BK_DIV_R;
      BK_DIV_R: if (dlast) st_nxt = BK_DONE;
      BK_DONE:  if (out_ready) st_nxt = BK_IDLE;
      default:  st_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= BK_IDLE;
    else        st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (load || (dstep && dlast)) begin
      step_r <= '0;
    end else if (dstep) begin
      step_r <= step_r + 1'b1;
    end
  end

  logic [NW-1:0] qnext;
  assign qnext = {quo_r[NW-2:0], ~sub[INDEX_BITS]};

  always_ff @(posedge clk) begin
    if (load) begin
      out_peak_index   <= pp;
      out_peak_value   <= pv;
      out_left_spread  <= pp - lp;
      out_right_spread <= rp - pp;
      dl_r  <= dl_w[SAMPLE_BITS-1:0];
      dr_r  <= dr_w[SAMPLE_BITS-1:0];
      dvd_r <= {dl_w[SAMPLE_BITS-1:0], {FRAC_BITS{1'b0}}};
      div_r <= pp - lp;
      rem_r <= '0;
      quo_r <= '0;
    end else if (dstep) begin
      if (dlast) begin
        if (st_r == BK_DIV_L) begin
          sl_r  <= (div_r == '0) ? '0 : qnext;
          dvd_r <= {dr_r, {FRAC_BITS{1'b0}}};
          div_r <= out_right_spread;
        end else begin
          sr_r  <= (div_r == '0) ? '0 : qnext;
        end
        rem_r <= '0;
        quo_r <= '0;
      end else begin
        rem_r <= sub[INDEX_BITS] ? trial : sub;
        quo_r <= qnext;
        dvd_r <= {dvd_r[NW-2:0], 1'b0};
      end
    end
  end

  assign ssum = {1'b0, sl_r} + {1'b0, sr_r};
  assign smax = (sl_r > sr_r) ? sl_r : sr_r;

  assign out_valid          = (st_r == BK_DONE);
  assign out_height_max     = (dl_r > dr_r) ? dl_r : dr_r;
  assign out_height_mean_x2 = {1'b0, dl_r} + {1'b0, dr_r};
  assign out_slope_max_q8   = smax;
  assign out_slope_mean_q8  = ssum[NW:1];

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
  assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (st_r == BK_DIV_L)) else $error("load did not start divide");
  assert property (@(posedge clk) disable iff (!rst_n)
    dstep |-> (step_r <= CW'(NW - 1))) else $error("divide step overrun");

endmodule

/* bench/tb_top.sv */
module tb_top;
  import pvfd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] peak_index;
    logic [15:0] peak_value;
    logic [15:0] left_spread;
    logic [15:0] right_spread;
    logic [15:0] height_max;
    logic [16:0] height_mean_x2;
    logic [23:0] slope_max_q8;
    logic [23:0] slope_mean_q8;
  } peak_feat_t;

  localparam int RESET_CYCLES = 11;
  localparam int SETTLE_CYCLES = 2 * (SAMPLE_BITS_DEF + FRAC_BITS) + 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  pvfd_stream_if #(.W(SAMPLE_BITS_DEF + 1)) in_if ();
  pvfd_stream_if #(.W($bits(peak_feat_t))) out_if ();

  peak_valley_feature_detector_core DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_if.valid),
    .in_ready          (in_if.ready),
    .in_sample         (in_if.data[16:1]),
    .in_is_last        (in_if.data[0]),
    .out_valid         (out_if.valid),
    .out_ready         (out_if.ready),
    .out_peak_index    (out_if.data[144:129]),
    .out_peak_value    (out_if.data[128:113]),
    .out_left_spread   (out_if.data[112:97]),
    .out_right_spread  (out_if.data[96:81]),
    .out_height_max    (out_if.data[80:65]),
    .out_height_mean_x2(out_if.data[64:48]),
    .out_slope_max_q8  (out_if.data[47:24]),
    .out_slope_mean_q8 (out_if.data[23:0])
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // detector state mirror
  logic signed [15:0] last_sample;
  logic [15:0] last_pos;
  logic [15:0] next_pos;
  bit have_last;
  bit found_valley;
  bit rising;
  logic signed [15:0] valley_val;
  logic [15:0] valley_pos;
  logic signed [15:0] peak_val;
  logic [15:0] peak_pos;

  peak_feat_t expected_peaks[$];
  int fail_count = 0;
  int items_sent = 0;
  int burst_left = 0;
  bit no_gaps = 0;
  int hold_req = 0;
  int hold_left = 0;
  int rx_mode = 0;
  int rx_cycle = 0;

  function automatic void clear_detector();
    last_sample = '0;
    last_pos = '0;
    next_pos = '0;
    have_last = 0;
    found_valley = 0;
    rising = 1;
    valley_val = '0;
    valley_pos = '0;
    peak_val = '0;
    peak_pos = '0;
  endfunction

  function automatic longint slope_of(longint height, logic [15:0] spread);
    if (spread == 0) return 0;
    return (height << 8) / spread;
  endfunction

  // closes the pending peak; the right valley becomes the next left one
  function automatic void close_peak(logic signed [15:0] rv, logic [15:0] rpos);
    longint dl, dr, sl, sr;
    logic [15:0] spl, spr;
    peak_feat_t f;
    dl = (peak_val >= valley_val) ? longint'(peak_val) - valley_val
                                  : longint'(valley_val) - peak_val;
    dr = (peak_val >= rv) ? longint'(peak_val) - rv : longint'(rv) - peak_val;
    spl = peak_pos - valley_pos;
    spr = rpos - peak_pos;
    sl = slope_of(dl, spl);
    sr = slope_of(dr, spr);
    f.peak_index = peak_pos;
    f.peak_value = peak_val;
    f.left_spread = spl;
    f.right_spread = spr;
    f.height_max = (dl > dr) ? dl[15:0] : dr[15:0];
    f.height_mean_x2 = 17'(dl + dr);
    f.slope_max_q8 = (sl > sr) ? sl[23:0] : sr[23:0];
    f.slope_mean_q8 = 24'((sl + sr) >> 1);
    expected_peaks.push_back(f);
    valley_val = rv;
    valley_pos = rpos;
  endfunction

  function automatic void predict_sample(logic signed [15:0] s, bit last);
    bit closed;
    closed = 0;
    if (have_last) begin
      if (s < last_sample) begin
        if (found_valley && rising) begin
          peak_val = last_sample;
          peak_pos = last_pos;
          rising = 0;
        end
      end else begin
        if (!found_valley) begin
          valley_val = last_sample;
          valley_pos = last_pos;
          found_valley = 1;
        end else if (!rising) begin
          close_peak(last_sample, last_pos);
          closed = 1;
        end
        rising = 1;
      end
    end
    if (last) begin
      // signal ending while falling closes with a valley at the last sample
      if (found_valley && !rising && !closed) close_peak(s, next_pos);
      clear_detector();
    end else begin
      last_sample = s;
      last_pos = next_pos;
      have_last = 1;
      if (next_pos != 16'hFFFF) next_pos = next_pos + 1;
    end
  endfunction

  task automatic send_sample(logic signed [15:0] s, bit last);
    int gap;
    if (!no_gaps && burst_left == 0) begin
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        in_if.data <= 17'($urandom);
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    if (burst_left > 0) burst_left--;
    in_if.valid <= 1'b1;
    in_if.data <= {s, last};
    do @(posedge clk); while (!in_if.ready);
    predict_sample(s, last);
    items_sent++;
  endtask

  task automatic go_idle();
    in_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    go_idle();
    while (expected_peaks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [15:0] clamp16(int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  task automatic send_list(int vals[]);
    foreach (vals[i]) send_sample(16'(vals[i]), i == vals.size() - 1);
  endtask

  task automatic test_directed();
    // extremes, fall before first valley, closing valley at the end
    send_list('{0, -32768, -32768, 32767, -32768, 32767, -1, -32768});
    send_list('{5});                   // single sample
    send_list('{100, 50, 0, -50});     // never rising
    send_list('{7, 7, 7});             // flat only
    send_list('{0, 5, 5, 0, 0});       // plateau peak, flat valley
    send_list('{0, 10, 3});            // peak turns on the last sample
    drain();
  endtask

  task automatic send_random_signal();
    int len, style, v, step;
    len = $urandom_range(2, 40);
    style = $urandom_range(0, 9);
    v = $signed(16'($urandom));
    if (style == 9) len = $urandom_range(1, 3);
    for (int i = 0; i < len; i++) begin
      if (style == 8) begin
        v = $signed(16'($urandom));     // noise
      end else if (style == 9) begin
        v = v - $urandom_range(0, 5000); // broken: short and falling
      end else begin
        case ($urandom_range(0, 5))
          0: step = $signed(17'($urandom)) / 2;
          1: step = 0;
          default: step = int'($urandom_range(0, 600)) - 300;
        endcase
        v = v + step;
      end
      v = clamp16(v);
      send_sample(16'(v), i == len - 1);
    end
  endtask

  task automatic test_random();
    int start;
    start = items_sent;
    while (items_sent - start < 460) begin
      no_gaps = ($urandom_range(0, 5) == 0);
      send_random_signal();
    end
    no_gaps = 0;
    drain();
  endtask

  // receiver holds off while a dense zigzag keeps offering items
  task automatic test_backpressure();
    hold_req = 400;
    no_gaps = 1;
    for (int i = 0; i < 60; i++)
      send_sample((i % 2) ? 16'sd1000 + 16'(i) : -16'sd1000 - 16'(i), i == 59);
    no_gaps = 0;
    drain();
  endtask

  function automatic void check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    peak_feat_t act, exp_f;
    if (rst_n && out_if.valid && out_if.ready) begin
      act = out_if.data;
      if (expected_peaks.size() == 0) begin
        $error("unexpected result item, peak_index %0d", act.peak_index);
        fail_count++;
      end else begin
        exp_f = expected_peaks.pop_front();
        check_field("peak_index", exp_f.peak_index, act.peak_index);
        check_field("peak_value", $signed(exp_f.peak_value), $signed(act.peak_value));
        check_field("left_spread", exp_f.left_spread, act.left_spread);
        check_field("right_spread", exp_f.right_spread, act.right_spread);
        check_field("height_max", exp_f.height_max, act.height_max);
        check_field("height_mean_x2", exp_f.height_mean_x2, act.height_mean_x2);
        check_field("slope_max_q8", exp_f.slope_max_q8, act.slope_max_q8);
        check_field("slope_mean_q8", exp_f.slope_mean_q8, act.slope_mean_q8);
      end
    end
    rx_cycle++;
    if (rx_cycle % 97 == 0) rx_mode = $urandom_range(0, 2);
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= ($urandom_range(0, 3) != 0);
        default: out_if.ready <= ((rx_cycle % 7) < 3);
      endcase
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    clear_detector();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    test_backpressure();
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_top failed");
    $finish;
  end

endmodule
